// ----- sv/sdms_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and function codes for the stable descending merge sort unit.
package sdms_pkg;

    localparam int MAX_RECORDS_DEF   = 1024;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

endpackage

// ----- sv/sdms_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: load, read and clear items with their record fields.
interface sdms_req_if #(
    parameter int KEY_WIDTH     = sdms_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = sdms_pkg::PAYLOAD_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic signed [KEY_WIDTH-1:0]     sort_key;
    logic [PAYLOAD_WIDTH-1:0]        first_payload;
    logic [PAYLOAD_WIDTH-1:0]        second_payload;
    logic                            last_in;

    modport source (
        output valid, func, sort_key, first_payload, second_payload, last_in,
        input  ready
    );

    modport sink (
        input  valid, func, sort_key, first_payload, second_payload, last_in,
        output ready
    );
endinterface

// ----- sv/sdms_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel: one item per read request.
interface sdms_rsp_if #(
    parameter int KEY_WIDTH     = sdms_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = sdms_pkg::PAYLOAD_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [KEY_WIDTH-1:0]     key_out;
    logic [PAYLOAD_WIDTH-1:0]        first_out;
    logic [PAYLOAD_WIDTH-1:0]        second_out;
    logic                            last_out;
    logic                            no_data;
    logic                            overflowed;

    modport source (
        output valid, key_out, first_out, second_out, last_out, no_data, overflowed,
        input  ready
    );

    modport sink (
        input  valid, key_out, first_out, second_out, last_out, no_data, overflowed,
        output ready
    );
endinterface

// ----- sv/sdms_rec_ram.sv -----
`timescale 1ns / 1ps
// Record memory: one write port, two registered read ports.
module sdms_rec_ram #(
    parameter int  DEPTH = sdms_pkg::MAX_RECORDS_DEF,
    parameter int  WIDTH = sdms_pkg::KEY_WIDTH_DEF + 2 * sdms_pkg::PAYLOAD_WIDTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] q0,
    output logic [WIDTH-1:0] q1
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] q0_reg;
    logic [WIDTH-1:0] q1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q0_reg <= mem[raddr0];
            q1_reg <= mem[raddr1];
        end
    end

    assign q0 = q0_reg;
    assign q1 = q1_reg;
endmodule

// ----- sv/sdms_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: load, read-out, clear and bottom-up merge over two record banks.
module sdms_ctrl #(
    parameter int  MAX_RECORDS   = sdms_pkg::MAX_RECORDS_DEF,
    parameter int  KEY_WIDTH     = sdms_pkg::KEY_WIDTH_DEF,
    parameter int  PAYLOAD_WIDTH = sdms_pkg::PAYLOAD_WIDTH_DEF,
    localparam int AW            = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
    localparam int REC_W         = KEY_WIDTH + 2 * PAYLOAD_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    sdms_req_if.sink         req,
    sdms_rsp_if.source       rsp,
    output logic [1:0]       ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [REC_W-1:0] ram_wdata,
    output logic [1:0]       ram_re,
    output logic [AW-1:0]    ram_raddr0,
    output logic [AW-1:0]    ram_raddr1,
    input  logic [REC_W-1:0] q0_a,
    input  logic [REC_W-1:0] q1_a,
    input  logic [REC_W-1:0] q0_b,
    input  logic [REC_W-1:0] q1_b
);
    import sdms_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int WW = CW + 2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_SEG  = 6'b000100,
        S_MRD  = 6'b001000,
        S_MWR  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ridx_reg, ridx_next;
    logic            sorted_reg, sorted_next;
    logic            ovf_reg, ovf_next;
    logic            res_b_reg, res_b_next;
    logic            src_b_reg, src_b_next;
    logic [WW-1:0]   run_reg, run_next;
    logic [WW-1:0]   lo_reg, lo_next;
    logic [WW-1:0]   mid_reg, mid_next;
    logic [WW-1:0]   hi_reg, hi_next;
    logic [WW-1:0]   a_reg, a_next;
    logic [WW-1:0]   b_reg, b_next;
    logic [WW-1:0]   o_reg, o_next;
    logic            rd_hit_reg, rd_hit_next;
    logic            rd_last_reg, rd_last_next;
    logic            rd_bank_reg, rd_bank_next;
    logic            out_valid_reg, out_valid_next;
    logic [REC_W-1:0] out_rec_reg;
    logic            out_last_reg;
    logic            out_nodata_reg;
    logic            out_ovf_reg;

    logic            accept;
    logic            out_load;
    logic [CW-1:0]   cnt_eff;
    logic [WW-1:0]   n_w;
    logic [WW-1:0]   lo_run;
    logic [WW-1:0]   lo_2run;
    logic [REC_W-1:0] qa;
    logic [REC_W-1:0] qb;
    logic [REC_W-1:0] rd_rec;
    logic            take_a;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign n_w       = WW'(count_reg);
    assign lo_run    = lo_reg + run_reg;
    assign lo_2run   = lo_reg + (run_reg << 1);
    assign cnt_eff   = sorted_reg ? '0 : count_reg;

    assign qa     = src_b_reg ? q0_b : q0_a;
    assign qb     = src_b_reg ? q1_b : q1_a;
    assign rd_rec = rd_bank_reg ? q0_b : q0_a;
    assign take_a = (a_reg < mid_reg) &&
                    ((b_reg >= hi_reg) ||
                     ($signed(qa[REC_W-1 -: KEY_WIDTH]) >= $signed(qb[REC_W-1 -: KEY_WIDTH])));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ridx_next      = ridx_reg;
        sorted_next    = sorted_reg;
        ovf_next       = ovf_reg;
        res_b_next     = res_b_reg;
        src_b_next     = src_b_reg;
        run_next       = run_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        o_next         = o_reg;
        rd_hit_next    = rd_hit_reg;
        rd_last_next   = rd_last_reg;
        rd_bank_next   = rd_bank_reg;
        out_load       = 1'b0;
        ram_we         = 2'b00;
        ram_waddr      = '0;
        ram_wdata      = {req.sort_key, req.first_payload, req.second_payload};
        ram_re         = 2'b00;
        ram_raddr0     = '0;
        ram_raddr1     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_LOAD:
                        begin
                            // a load after a sort opens a new batch
                            sorted_next = 1'b0;
                            ridx_next   = sorted_reg ? '0 : ridx_reg;
                            ovf_next    = sorted_reg ? 1'b0 : ovf_reg;
                            if (cnt_eff < CW'(MAX_RECORDS))
                            begin
                                ram_we     = 2'b01;
                                ram_waddr  = AW'(cnt_eff);
                                count_next = cnt_eff + CW'(1);
                            end
                            else
                            begin
                                ovf_next   = 1'b1;
                                count_next = cnt_eff;
                            end
                            if (req.last_in)
                            begin
                                run_next   = WW'(1);
                                lo_next    = '0;
                                src_b_next = 1'b0;
                                state_next = S_SEG;
                            end
                        end
                        FUNC_READ:
                        begin
                            rd_hit_next  = sorted_reg && (ridx_reg < count_reg);
                            rd_last_next = ((ridx_reg + CW'(1)) == count_reg);
                            rd_bank_next = res_b_reg;
                            ram_raddr0   = AW'(ridx_reg);
                            if (sorted_reg && (ridx_reg < count_reg))
                            begin
                                ram_re    = res_b_reg ? 2'b10 : 2'b01;
                                ridx_next = ridx_reg + CW'(1);
                            end
                            state_next = S_RD;
                        end
                        FUNC_CLEAR:
                        begin
                            count_next  = '0;
                            ridx_next   = '0;
                            sorted_next = 1'b0;
                            ovf_next    = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                // read data holds until the output slot frees
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SEG:
            begin
                if (run_reg >= n_w)
                begin
                    sorted_next = 1'b1;
                    ridx_next   = '0;
                    res_b_next  = src_b_reg;
                    state_next  = S_IDLE;
                end
                else if (lo_reg >= n_w)
                begin
                    run_next   = run_reg << 1;
                    lo_next    = '0;
                    src_b_next = !src_b_reg;
                end
                else
                begin
                    mid_next   = (lo_run < n_w) ? lo_run : n_w;
                    hi_next    = (lo_2run < n_w) ? lo_2run : n_w;
                    a_next     = lo_reg;
                    b_next     = (lo_run < n_w) ? lo_run : n_w;
                    o_next     = lo_reg;
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                ram_re     = src_b_reg ? 2'b10 : 2'b01;
                ram_raddr0 = AW'(a_reg);
                ram_raddr1 = AW'(b_reg);
                state_next = S_MWR;
            end
            S_MWR:
            begin
                ram_we    = src_b_reg ? 2'b01 : 2'b10;
                ram_waddr = AW'(o_reg);
                ram_wdata = take_a ? qa : qb;
                if (take_a)
                begin
                    a_next = a_reg + WW'(1);
                end
                else
                begin
                    b_next = b_reg + WW'(1);
                end
                o_next = o_reg + WW'(1);
                if ((o_reg + WW'(1)) == hi_reg)
                begin
                    lo_next    = lo_2run;
                    state_next = S_SEG;
                end
                else
                begin
                    state_next = S_MRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ridx_reg      <= '0;
            sorted_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            res_b_reg     <= 1'b0;
            src_b_reg     <= 1'b0;
            run_reg       <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            o_reg         <= '0;
            rd_hit_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            rd_bank_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ridx_reg      <= ridx_next;
            sorted_reg    <= sorted_next;
            ovf_reg       <= ovf_next;
            res_b_reg     <= res_b_next;
            src_b_reg     <= src_b_next;
            run_reg       <= run_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            o_reg         <= o_next;
            rd_hit_reg    <= rd_hit_next;
            rd_last_reg   <= rd_last_next;
            rd_bank_reg   <= rd_bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rec_reg    <= rd_hit_reg ? rd_rec : '0;
            out_last_reg   <= rd_hit_reg && rd_last_reg;
            out_nodata_reg <= !rd_hit_reg;
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.key_out    = out_rec_reg[REC_W-1 -: KEY_WIDTH];
    assign rsp.first_out  = out_rec_reg[2*PAYLOAD_WIDTH-1 -: PAYLOAD_WIDTH];
    assign rsp.second_out = out_rec_reg[PAYLOAD_WIDTH-1:0];
    assign rsp.last_out   = out_last_reg;
    assign rsp.no_data    = out_nodata_reg;
    assign rsp.overflowed = out_ovf_reg;
endmodule

// ----- sv/stable_descending_merge_sort_unit.sv -----
`timescale 1ns / 1ps
// Top level: stable descending merge sorter with two ping-pong record banks.
//
//  channel  dir  item
//  req      in   func, sort_key, first_payload, second_payload, last_in
//  rsp      out  key_out, first_out, second_out, last_out, no_data, overflowed
//
// Load and clear finish in S_IDLE; a read passes the bank read register, then the output
// register. A load with last_in starts the bottom-up merge: each pass walks its run pairs,
// and per record the merge loop reads the two run heads (S_MRD), then writes one (S_MWR).
// req.ready is low during the merge and while a read waits for the output register.
// rsp is a registered slot; it holds while rsp.ready is low. Reset is async, active low.
module stable_descending_merge_sort_unit #(
    parameter int MAX_RECORDS   = sdms_pkg::MAX_RECORDS_DEF,
    parameter int KEY_WIDTH     = sdms_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = sdms_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sdms_req_if.sink   req,
    sdms_rsp_if.source rsp
);
    import sdms_pkg::*;

    localparam int AW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int REC_W = KEY_WIDTH + 2 * PAYLOAD_WIDTH;

    logic [1:0]       ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic [1:0]       ram_re;
    logic [AW-1:0]    ram_raddr0;
    logic [AW-1:0]    ram_raddr1;
    logic [REC_W-1:0] q0_a;
    logic [REC_W-1:0] q1_a;
    logic [REC_W-1:0] q0_b;
    logic [REC_W-1:0] q1_b;

    sdms_ctrl #(
        .MAX_RECORDS   (MAX_RECORDS),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr0 (ram_raddr0),
        .ram_raddr1 (ram_raddr1),
        .q0_a       (q0_a),
        .q1_a       (q1_a),
        .q0_b       (q0_b),
        .q1_b       (q1_b)
    );

    // bank a: load target; banks a and b alternate as merge source and destination
    sdms_rec_ram #(
        .DEPTH (MAX_RECORDS),
        .WIDTH (REC_W)
    ) u_bank_a (
        .clk    (clk),
        .we     (ram_we[0]),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re[0]),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .q0     (q0_a),
        .q1     (q1_a)
    );

    sdms_rec_ram #(
        .DEPTH (MAX_RECORDS),
        .WIDTH (REC_W)
    ) u_bank_b (
        .clk    (clk),
        .we     (ram_we[1]),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re[1]),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .q0     (q0_b),
        .q1     (q1_b)
    );
endmodule

// ----- verif/stable_descending_merge_sort_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the stable descending merge sort unit: directed and random requests.
module stable_descending_merge_sort_unit_test;

    import sdms_pkg::*;

    localparam int KW            = KEY_WIDTH_DEF;
    localparam int PW            = PAYLOAD_WIDTH_DEF;
    localparam int CAPACITY      = MAX_RECORDS_DEF;
    localparam int ITEMS         = 1650;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 200000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]            func;
        logic signed [KW-1:0]  key;
        logic [PW-1:0]         first;
        logic [PW-1:0]         second;
        logic                  last;
        int                    gap;
        bit                    drain;
    } request_t;

    typedef struct {
        logic signed [KW-1:0]  key;
        logic [PW-1:0]         first;
        logic [PW-1:0]         second;
    } record_t;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [PW-1:0] first;
        logic [PW-1:0] second;
        logic          last;
        logic          no_data;
        logic          overflowed;
    } read_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sdms_req_if req_ch ();
    sdms_rsp_if rsp_ch ();

    stable_descending_merge_sort_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    request_t     request_q[$];
    read_result_t read_results_q[$];

    // predictor state
    record_t held_recs[CAPACITY];
    int      held_count   = 0;
    int      next_read    = 0;
    bit      batch_sorted = 1'b0;
    bit      dropped_load = 1'b0;

    int errors      = 0;
    int stim_total  = 0;
    bit calm        = 1'b0;
    int n_loads     = 0;
    int n_reads     = 0;
    int n_clears    = 0;
    int n_sorts     = 0;
    int n_no_data   = 0;
    int n_ovf       = 0;
    int n_results   = 0;
    int n_full_sort = 0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KW-1:0] pick_key(int mode);
        logic [KW-1:0] k;
        k = $urandom;
        if (mode == 1)
        begin
            k = $urandom_range(0, 4);
            k = k - 2;
        end
        else if (mode == 2)
        begin
            case ($urandom_range(0, 4))
                0: k = {1'b1, {(KW-1){1'b0}}};
                1: k = {1'b0, {(KW-1){1'b1}}};
                2: k = '0;
                3: k = '1;
                default: k = $urandom;
            endcase
        end
        return k;
    endfunction

    task automatic push_req(logic [1:0] f, logic [KW-1:0] k, logic [PW-1:0] a,
                            logic [PW-1:0] b, logic lst, bit drn);
        request_t it;
        it.func   = f;
        it.key    = k;
        it.first  = a;
        it.second = b;
        it.last   = lst;
        it.gap    = calm ? 0 : idle_len();
        it.drain  = drn;
        request_q.push_back(it);
        stim_total++;
    endtask

    // a load / sort / read-out sequence with occasional noise and broken shapes
    task automatic build_batch();
        int  n;
        int  nr;
        int  kmode;
        bit  sealed;
        calm   = ($urandom_range(0, 3) == 0);
        n      = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 60);
        kmode  = $urandom_range(0, 2);
        sealed = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                case ($urandom_range(0, 2))
                    0: push_req(FUNC_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1), 0);
                    1: push_req(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1), 0);
                    default: push_req(FUNC_UNUSED, $urandom, $urandom, $urandom,
                                      $urandom_range(0, 1), 0);
                endcase
            end
            push_req(FUNC_LOAD, pick_key(kmode), $urandom, $urandom, sealed && (i == n - 1),
                     (i == 0) && ($urandom_range(0, 5) == 0));
        end
        if (!sealed)
            nr = $urandom_range(0, 2);
        else if ($urandom_range(0, 99) < 85)
            nr = n + $urandom_range(0, 2);
        else
            nr = $urandom_range(0, n);
        for (int i = 0; i < nr; i++)
            push_req(FUNC_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1), 0);
        if ($urandom_range(0, 9) == 0)
            push_req(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1), 0);
    endtask

    task automatic sort_unit_step(logic [1:0] f, logic signed [KW-1:0] k, logic [PW-1:0] a,
                                  logic [PW-1:0] b, logic lst);
        read_result_t r;
        record_t      tmp;
        int           j;
        case (f)
            FUNC_LOAD:
            begin
                n_loads++;
                if (batch_sorted)
                begin
                    held_count   = 0;
                    next_read    = 0;
                    batch_sorted = 1'b0;
                    dropped_load = 1'b0;
                end
                if (held_count < CAPACITY)
                begin
                    held_recs[held_count].key    = k;
                    held_recs[held_count].first  = a;
                    held_recs[held_count].second = b;
                    held_count++;
                end
                else
                    dropped_load = 1'b1;
                if (lst)
                begin
                    // stable: equal keys never move past each other
                    for (int i = 1; i < held_count; i++)
                    begin
                        tmp = held_recs[i];
                        j   = i;
                        while (j > 0 && $signed(held_recs[j-1].key) < $signed(tmp.key))
                        begin
                            held_recs[j] = held_recs[j-1];
                            j--;
                        end
                        held_recs[j] = tmp;
                    end
                    next_read    = 0;
                    batch_sorted = 1'b1;
                    n_sorts++;
                    if (held_count == CAPACITY)
                        n_full_sort++;
                end
            end
            FUNC_READ:
            begin
                n_reads++;
                r = '0;
                if (batch_sorted && next_read < held_count)
                begin
                    r.key    = held_recs[next_read].key;
                    r.first  = held_recs[next_read].first;
                    r.second = held_recs[next_read].second;
                    r.last   = (next_read + 1 == held_count);
                    next_read++;
                end
                else
                    r.no_data = 1'b1;
                r.overflowed = dropped_load;
                read_results_q.push_back(r);
            end
            FUNC_CLEAR:
            begin
                n_clears++;
                held_count   = 0;
                next_read    = 0;
                batch_sorted = 1'b0;
                dropped_load = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : driver_proc
        request_t it;
        bit       reads_open;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            reads_open = (read_results_q.size() != 0) ||
                         (req_ch.valid && req_ch.ready && req_ch.func == FUNC_READ);
            if (request_q.size() == 0)
                req_ch.valid <= 1'b0;
            else if (request_q[0].gap > 0)
            begin
                request_q[0].gap = request_q[0].gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (request_q[0].drain && reads_open)
                req_ch.valid <= 1'b0;
            else
            begin
                it = request_q.pop_front();
                req_ch.func           <= it.func;
                req_ch.sort_key       <= it.key;
                req_ch.first_payload  <= it.first;
                req_ch.second_payload <= it.second;
                req_ch.last_in        <= it.last;
                req_ch.valid          <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : rsp_ready_proc
        static int reads_sent = 0;
        static int hold_left  = 0;
        static int stall_left = 0;
        static int phase      = 0;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready && req_ch.func == FUNC_READ)
            begin
                reads_sent++;
                if (reads_sent == 40 || reads_sent == 400)
                    hold_left = LONG_HOLD;
            end
            phase = (phase + 1) % 512;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (phase < 128)
                rsp_ch.ready <= 1'b1;
            else
            begin
                stall_left = idle_len();
                if (stall_left == 0)
                    rsp_ch.ready <= 1'b1;
                else
                begin
                    stall_left--;
                    rsp_ch.ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor_proc
        read_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sort_unit_step(req_ch.func, req_ch.sort_key, req_ch.first_payload,
                               req_ch.second_payload, req_ch.last_in);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results++;
                if (rsp_ch.no_data === 1'b1)
                    n_no_data++;
                if (rsp_ch.overflowed === 1'b1)
                    n_ovf++;
                if (read_results_q.size() == 0)
                begin
                    $error("response item with no read outstanding");
                    errors++;
                end
                else
                begin
                    want = read_results_q.pop_front();
                    check_field("key_out", want.key, rsp_ch.key_out);
                    check_field("first_out", want.first, rsp_ch.first_out);
                    check_field("second_out", want.second, rsp_ch.second_out);
                    check_field("last_out", want.last, rsp_ch.last_out);
                    check_field("no_data", want.no_data, rsp_ch.no_data);
                    check_field("overflowed", want.overflowed, rsp_ch.overflowed);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        static int idle_cycles = 0;
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == STALL_LIMIT)
            begin
                $error("no item moved for %0d cycles, %0d reads outstanding",
                       STALL_LIMIT, read_results_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.func           = FUNC_LOAD;
        req_ch.sort_key       = '0;
        req_ch.first_payload  = '0;
        req_ch.second_payload = '0;
        req_ch.last_in        = 1'b0;
        rsp_ch.ready          = 1'b0;

        // directed: empty reads, ignored code, key extremes, ties, read past end,
        // single-record batch, new batch after a sort, clear
        push_req(FUNC_READ, $urandom, $urandom, $urandom, 1'b1, 0);
        push_req(FUNC_UNUSED, '1, '1, '1, 1'b1, 0);
        push_req(FUNC_LOAD, {1'b0, {(KW-1){1'b1}}}, '0, '0, 1'b0, 0);
        push_req(FUNC_LOAD, {1'b1, {(KW-1){1'b0}}}, '1, '1, 1'b0, 0);
        push_req(FUNC_READ, '0, '0, '0, 1'b0, 0);
        push_req(FUNC_LOAD, '0, 32'h0000_0010, 32'hA5A5_5A5A, 1'b0, 0);
        push_req(FUNC_LOAD, '1, 32'h0000_0020, 32'h5A5A_A5A5, 1'b0, 0);
        push_req(FUNC_LOAD, 32'sd5, 32'h1, 32'h1, 1'b0, 0);
        push_req(FUNC_LOAD, 32'sd5, 32'h2, 32'h2, 1'b0, 0);
        push_req(FUNC_LOAD, 32'sd5, 32'h3, 32'h3, 1'b1, 0);
        for (int i = 0; i < 8; i++)
            push_req(FUNC_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1), 0);
        push_req(FUNC_LOAD, 32'sd7, $urandom, $urandom, 1'b1, 1);
        push_req(FUNC_READ, '0, '0, '0, 1'b0, 0);
        push_req(FUNC_READ, '0, '0, '0, 1'b0, 0);
        push_req(FUNC_LOAD, 32'sd9, $urandom, $urandom, 1'b0, 0);
        push_req(FUNC_CLEAR, '0, '0, '0, 1'b0, 0);
        push_req(FUNC_READ, '0, '0, '0, 1'b0, 0);

        while (stim_total < 350)
            build_batch();

        // full store with many equal keys, two dropped loads, the second one sealing
        calm = 1'b1;
        push_req(FUNC_CLEAR, $urandom, $urandom, $urandom, 1'b0, 1);
        for (int i = 0; i < CAPACITY + 2; i++)
            push_req(FUNC_LOAD, pick_key(($urandom_range(0, 3) == 0) ? 0 : 1), $urandom,
                     $urandom, (i == CAPACITY + 1), 0);
        calm = 1'b0;
        for (int i = 0; i < 40; i++)
            push_req(FUNC_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1), 0);

        while (stim_total < ITEMS)
            build_batch();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || req_ch.valid || read_results_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d loads, %0d reads, %0d clears; %0d sorts, %0d of a full store",
                 n_loads, n_reads, n_clears, n_sorts, n_full_sort);
        $display("Checked %0d results: %0d with no_data, %0d with overflowed set",
                 n_results, n_no_data, n_ovf);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
